>>> src/rgb_3x3_convolution_clamped_assert.svh
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_clamped_assert
// Assertion macros shared by the filter modules.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_CONVOLUTION_CLAMPED_ASSERT_SVH
`define RGB_3X3_CONVOLUTION_CLAMPED_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGBCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rgbcc_pkg.sv
// ----------------------------------------------------------------------------
// rgbcc_pkg
// Types, constants and helpers shared by the 3x3 RGB filter modules.
// ----------------------------------------------------------------------------
package rgbcc_pkg;

    // Default frame size
    localparam int FRAME_WIDTH_DEF  = 8;
    localparam int FRAME_HEIGHT_DEF = 16;

    // Payload and arithmetic widths
    localparam int PIX_W      = 8;
    localparam int CHANNELS   = 3;
    localparam int WORD_W     = PIX_W * CHANNELS;
    localparam int COEF_W     = 9;
    localparam int ROW_COEF_W = 3 * COEF_W;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int ACC_W      = 13;
    localparam int SCALE_W    = ACC_W + GAIN_W;
    localparam int OUT_COL_W  = 3;
    localparam int OUT_ROW_W  = 4;
    localparam int PIXEL_MAX  = 255;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_COEFF_ABOVE = 2'd0,
        REG_COEFF_SAME  = 2'd1,
        REG_COEFF_BELOW = 2'd2,
        REG_GAIN_RECIP  = 2'd3
    } t_reg_idx;

    localparam logic [ROW_COEF_W-1:0] COEFF_ABOVE_RST = ROW_COEF_W'(0);
    localparam logic [ROW_COEF_W-1:0] COEFF_SAME_RST  = ROW_COEF_W'(91648);
    localparam logic [ROW_COEF_W-1:0] COEFF_BELOW_RST = ROW_COEF_W'(13500467);
    localparam logic [GAIN_W-1:0]     GAIN_RECIP_RST  = GAIN_W'(31357);

    typedef struct packed {
        logic [ROW_COEF_W-1:0] above;
        logic [ROW_COEF_W-1:0] same;
        logic [ROW_COEF_W-1:0] below;
        logic [GAIN_W-1:0]     gain;
    } t_cfg;

    // Line store line index (row mod 3)
    typedef logic [1:0] t_line;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_DRAIN,
        S_SCALE,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input item, write it to the line store
        logic advance;  // step to the next raster position
        logic tap;      // issue one kernel tap read
        logic scale;    // apply the reciprocal gain
        logic load;     // load the output register
        logic next;     // move to the next result of this item
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic has_work;
        logic tap_last;
        logic out_free;
        logic more;
    } t_status;

    function automatic t_line line_inc(input t_line l);
        t_line r;
        r = (l == 2'd2) ? 2'd0 : l + 2'd1;
        return r;
    endfunction

    function automatic t_line line_dec(input t_line l);
        t_line r;
        r = (l == 2'd0) ? 2'd2 : l - 2'd1;
        return r;
    endfunction

endpackage

>>> src/rgb_3x3_convolution_clamped.sv
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_clamped: 3x3 RGB filter with edge clamp and saturation
// An item is taken in the idle state; each result then takes nine tap reads
// through the line store's single read port, a drain, a scale and a load that
// waits for a free output register. An item has 0, 1, 2 or width + 2 results.
// Reset clears counters and control and loads default config; no store clear.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_clamped #(
    parameter int FRAME_WIDTH  = rgbcc_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = rgbcc_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgbcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rgbcc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rgbcc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    // pixel input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rgbcc_pkg::PIX_W-1:0]         i_red_in,
    input  logic [rgbcc_pkg::PIX_W-1:0]         i_green_in,
    input  logic [rgbcc_pkg::PIX_W-1:0]         i_blue_in,
    // filtered output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rgbcc_pkg::PIX_W-1:0]         o_red_out,
    output logic [rgbcc_pkg::PIX_W-1:0]         o_green_out,
    output logic [rgbcc_pkg::PIX_W-1:0]         o_blue_out,
    output logic [rgbcc_pkg::OUT_COL_W-1:0]     o_out_column,
    output logic [rgbcc_pkg::OUT_ROW_W-1:0]     o_out_row,
    output logic                                o_run_last,
    output logic                                o_frame_last
);

    rgbcc_pkg::t_cfg    cfg;
    rgbcc_pkg::t_cmd    cmd;
    rgbcc_pkg::t_status st;

    // Configuration registers
    rgbcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    rgbcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Datapath
    rgbcc_dp #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

endmodule

>>> src/rgbcc_ram.sv
// ----------------------------------------------------------------------------
// rgbcc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/rgbcc_regs.sv
// ----------------------------------------------------------------------------
// rgbcc_regs
// APB-style configuration registers: three coefficient rows and the gain.
// ----------------------------------------------------------------------------
module rgbcc_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgbcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rgbcc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rgbcc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output rgbcc_pkg::t_cfg                     o_cfg
);

    localparam int CRW = rgbcc_pkg::ROW_COEF_W;
    localparam int GW  = rgbcc_pkg::GAIN_W;
    localparam int DW  = rgbcc_pkg::APB_DATA_W;

    logic [CRW-1:0] r_above;
    logic [CRW-1:0] r_same;
    logic [CRW-1:0] r_below;
    logic [GW-1:0]  r_gain;
    logic           wr_en;
    rgbcc_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = rgbcc_pkg::t_reg_idx'(paddr[3:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= rgbcc_pkg::COEFF_ABOVE_RST;
            r_same  <= rgbcc_pkg::COEFF_SAME_RST;
            r_below <= rgbcc_pkg::COEFF_BELOW_RST;
            r_gain  <= rgbcc_pkg::GAIN_RECIP_RST;
        end else if (wr_en) begin
            case (idx)
                rgbcc_pkg::REG_COEFF_ABOVE: r_above <= pwdata[CRW-1:0];
                rgbcc_pkg::REG_COEFF_SAME:  r_same  <= pwdata[CRW-1:0];
                rgbcc_pkg::REG_COEFF_BELOW: r_below <= pwdata[CRW-1:0];
                rgbcc_pkg::REG_GAIN_RECIP:  r_gain  <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            rgbcc_pkg::REG_COEFF_ABOVE: prdata = DW'(r_above);
            rgbcc_pkg::REG_COEFF_SAME:  prdata = DW'(r_same);
            rgbcc_pkg::REG_COEFF_BELOW: prdata = DW'(r_below);
            rgbcc_pkg::REG_GAIN_RECIP:  prdata = DW'(r_gain);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.above = r_above;
    assign o_cfg.same  = r_same;
    assign o_cfg.below = r_below;
    assign o_cfg.gain  = r_gain;

endmodule

>>> src/rgbcc_ctrl.sv
// ----------------------------------------------------------------------------
// rgbcc_ctrl
// Sequencer: accepts an item, then runs nine tap reads, scaling and output
// per result until the item has no more results.
// ----------------------------------------------------------------------------
`include "rgb_3x3_convolution_clamped_assert.svh"

module rgbcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rgbcc_pkg::t_status  i_st,
    output rgbcc_pkg::t_cmd     o_cmd
);

    rgbcc_pkg::t_state r_state;
    rgbcc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgbcc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            rgbcc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.has_work) begin
                        n_state = rgbcc_pkg::S_TAP;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            rgbcc_pkg::S_TAP: begin
                o_cmd.tap = 1'b1;
                if (i_st.tap_last) begin
                    n_state = rgbcc_pkg::S_DRAIN;
                end
            end
            rgbcc_pkg::S_DRAIN: begin
                n_state = rgbcc_pkg::S_SCALE;
            end
            rgbcc_pkg::S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = rgbcc_pkg::S_EMIT;
            end
            rgbcc_pkg::S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_st.more) begin
                        o_cmd.next = 1'b1;
                        n_state    = rgbcc_pkg::S_TAP;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = rgbcc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = rgbcc_pkg::S_IDLE;
            end
        endcase
    end

    // Checks
    `RGBCC_ASSERT_NOW(a_load_free, i_clk, i_rst_n, o_cmd.load, i_st.out_free,
                      "output register loaded while occupied")
    `RGBCC_ASSERT_NEXT(a_work_starts, i_clk, i_rst_n,
                       o_cmd.accept && i_st.has_work, r_state == rgbcc_pkg::S_TAP,
                       "item with results did not start tap reads")

endmodule

>>> src/rgbcc_dp.sv
// ----------------------------------------------------------------------------
// rgbcc_dp
// Datapath: raster counters, line store, tap address clamp, per-channel
// multiply-accumulate, gain scaling, saturation and output register.
// ----------------------------------------------------------------------------
`include "rgb_3x3_convolution_clamped_assert.svh"

module rgbcc_dp #(
    parameter int FRAME_WIDTH  = rgbcc_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = rgbcc_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rgbcc_pkg::t_cfg                     i_cfg,
    input  rgbcc_pkg::t_cmd                     i_cmd,
    output rgbcc_pkg::t_status                  o_st,
    input  logic [rgbcc_pkg::PIX_W-1:0]         i_red_in,
    input  logic [rgbcc_pkg::PIX_W-1:0]         i_green_in,
    input  logic [rgbcc_pkg::PIX_W-1:0]         i_blue_in,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [rgbcc_pkg::PIX_W-1:0]         o_red_out,
    output logic [rgbcc_pkg::PIX_W-1:0]         o_green_out,
    output logic [rgbcc_pkg::PIX_W-1:0]         o_blue_out,
    output logic [rgbcc_pkg::OUT_COL_W-1:0]     o_out_column,
    output logic [rgbcc_pkg::OUT_ROW_W-1:0]     o_out_row,
    output logic                                o_run_last,
    output logic                                o_frame_last
);

    localparam int CW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int RW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int DEPTH = 3 * FRAME_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = rgbcc_pkg::PIX_W;
    localparam int NCH   = rgbcc_pkg::CHANNELS;
    localparam int WW    = rgbcc_pkg::WORD_W;
    localparam int KW    = rgbcc_pkg::COEF_W;
    localparam int CRW   = rgbcc_pkg::ROW_COEF_W;
    localparam int FW    = rgbcc_pkg::FRAC_W;
    localparam int MW    = rgbcc_pkg::PROD_W;
    localparam int ACW   = rgbcc_pkg::ACC_W;
    localparam int GW    = rgbcc_pkg::GAIN_W;
    localparam int SW    = rgbcc_pkg::SCALE_W;
    localparam int OCW   = rgbcc_pkg::OUT_COL_W;
    localparam int ORW   = rgbcc_pkg::OUT_ROW_W;

    localparam logic [CW-1:0] COL_LAST   = CW'(FRAME_WIDTH - 1);
    localparam logic [CW-1:0] COL_PENULT = CW'(FRAME_WIDTH - 2);
    localparam logic [RW-1:0] ROW_LAST   = RW'(FRAME_HEIGHT - 1);
    localparam logic [AW-1:0] BASE_1     = AW'(FRAME_WIDTH);
    localparam logic [AW-1:0] BASE_2     = AW'(2 * FRAME_WIDTH);
    localparam logic [PW-1:0] PIX_SAT    = PW'(rgbcc_pkg::PIXEL_MAX);

    // Raster position and result position
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    rgbcc_pkg::t_line     r_line;
    logic [CW-1:0]        r_res_x;
    logic                 r_flush;

    // Tap counters and MAC pipeline
    logic [1:0]           r_dy;
    logic [1:0]           r_dx;
    logic [1:0]           r_dy_d;
    logic [1:0]           r_dx_d;
    logic                 r_mac_v;
    logic [NCH-1:0][ACW-1:0] r_acc;
    logic [NCH-1:0][ACW-1:0] r_scaled;

    // Output register
    logic                 r_out_v;
    logic [NCH-1:0][PW-1:0] r_out_ch;
    logic [OCW-1:0]       r_out_col;
    logic [ORW-1:0]       r_out_row;
    logic                 r_out_rl;
    logic                 r_out_fl;

    logic [RW-1:0]        res_y;
    rgbcc_pkg::t_line     res_line;
    rgbcc_pkg::t_line     tap_line;
    logic [CW-1:0]        tap_col;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [WW-1:0]        wr_data;
    logic [WW-1:0]        rd_data;
    logic [CRW-1:0]       coef_row;
    logic [KW-1:0]        coef;
    logic [NCH-1:0][MW-1:0] prod;
    logic [NCH-1:0][ACW-1:0] n_acc;
    logic [NCH-1:0][SW-1:0]  gain_prod;
    logic [NCH-1:0][PW-1:0]  sat;
    logic                 frame_end;
    logic                 norm_more;
    logic                 to_flush;
    logic                 flush_more;
    logic                 more;
    logic                 out_free;

    function automatic logic [AW-1:0] line_base(input rgbcc_pkg::t_line l);
        logic [AW-1:0] b;
        case (l)
            2'd1:    b = BASE_1;
            2'd2:    b = BASE_2;
            default: b = '0;
        endcase
        return b;
    endfunction

    // Row and line of the result being computed
    assign res_y    = r_flush ? r_row : r_row - RW'(1);
    assign res_line = r_flush ? r_line : rgbcc_pkg::line_dec(r_line);

    // Edge clamp on rows and columns
    always_comb begin
        case (r_dy)
            2'd0:    tap_line = (res_y == '0) ? res_line : rgbcc_pkg::line_dec(res_line);
            2'd1:    tap_line = res_line;
            default: tap_line = (res_y == ROW_LAST) ? res_line
                                                    : rgbcc_pkg::line_inc(res_line);
        endcase
        case (r_dx)
            2'd0:    tap_col = (r_res_x == '0) ? r_res_x : r_res_x - CW'(1);
            2'd1:    tap_col = r_res_x;
            default: tap_col = (r_res_x == COL_LAST) ? r_res_x : r_res_x + CW'(1);
        endcase
    end

    assign rd_addr = line_base(tap_line) + AW'(tap_col);
    assign wr_addr = line_base(r_line) + AW'(r_col);
    assign wr_data = {i_blue_in, i_green_in, i_red_in};

    // Line store: three rows of packed pixels
    rgbcc_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Coefficient of the tap whose data is arriving
    always_comb begin
        case (r_dy_d)
            2'd0:    coef_row = i_cfg.above;
            2'd1:    coef_row = i_cfg.same;
            default: coef_row = i_cfg.below;
        endcase
        case (r_dx_d)
            2'd0:    coef = coef_row[KW-1:0];
            2'd1:    coef = coef_row[2*KW-1:KW];
            default: coef = coef_row[3*KW-1:2*KW];
        endcase
    end

    // Products truncated to integers, then summed; gain and saturation
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            prod[ch]      = MW'(rd_data[ch*PW +: PW]) * MW'(coef);
            n_acc[ch]     = ((r_dy_d == 2'd0 && r_dx_d == 2'd0) ? '0 : r_acc[ch])
                            + ACW'(prod[ch][MW-1:FW]);
            gain_prod[ch] = SW'(r_acc[ch]) * SW'(i_cfg.gain);
            sat[ch]       = (r_scaled[ch][ACW-1:PW] != '0) ? PIX_SAT
                                                          : r_scaled[ch][PW-1:0];
        end
    end

    // Remaining results of this item
    assign frame_end  = (r_col == COL_LAST) && (r_row == ROW_LAST);
    assign norm_more  = !r_flush && (r_col == COL_LAST) && (r_res_x == COL_PENULT);
    assign to_flush   = !r_flush && !norm_more && frame_end;
    assign flush_more = r_flush && (r_res_x != COL_LAST);
    assign more       = norm_more || to_flush || flush_more;
    assign out_free   = !r_out_v || !i_out_stall;

    assign o_st.has_work = (r_row != '0) && (r_col != '0);
    assign o_st.tap_last = (r_dy == 2'd2) && (r_dx == 2'd2);
    assign o_st.out_free = out_free;
    assign o_st.more     = more;

    // Raster counters and result position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_line  <= 2'd0;
            r_res_x <= '0;
            r_flush <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_res_x <= r_col - CW'(1);
            end else if (i_cmd.next) begin
                if (to_flush) begin
                    r_res_x <= '0;
                    r_flush <= 1'b1;
                end else begin
                    r_res_x <= r_res_x + CW'(1);
                end
            end
            if (i_cmd.advance) begin
                r_flush <= 1'b0;
                if (r_col == COL_LAST) begin
                    r_col <= '0;
                    if (r_row == ROW_LAST) begin
                        r_row  <= '0;
                        r_line <= 2'd0;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_line <= rgbcc_pkg::line_inc(r_line);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Tap counters and read-data alignment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dy    <= 2'd0;
            r_dx    <= 2'd0;
            r_mac_v <= 1'b0;
        end else begin
            r_mac_v <= i_cmd.tap;
            if (i_cmd.tap) begin
                if (r_dx == 2'd2) begin
                    r_dx <= 2'd0;
                    r_dy <= (r_dy == 2'd2) ? 2'd0 : r_dy + 2'd1;
                end else begin
                    r_dx <= r_dx + 2'd1;
                end
            end
        end
    end

    // Accumulate and scale
    always_ff @(posedge i_clk) begin
        r_dy_d <= r_dy;
        r_dx_d <= r_dx;
        if (r_mac_v) begin
            r_acc <= n_acc;
        end
        if (i_cmd.scale) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_scaled[ch] <= gain_prod[ch][SW-1:GW];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_ch  <= sat;
            r_out_col <= OCW'(r_res_x);
            r_out_row <= ORW'(res_y);
            r_out_rl  <= !more;
            r_out_fl  <= (r_res_x == COL_LAST) && (res_y == ROW_LAST);
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_red_out    = r_out_ch[0];
    assign o_green_out  = r_out_ch[1];
    assign o_blue_out   = r_out_ch[2];
    assign o_out_column = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_run_last   = r_out_rl;
    assign o_frame_last = r_out_fl;

    // Checks
    `RGBCC_ASSERT_NOW(a_flush_pos, i_clk, i_rst_n, r_flush,
                      (r_col == COL_LAST) && (r_row == ROW_LAST),
                      "last-row flush away from the final pixel")
    `RGBCC_ASSERT_NOW(a_accept_quiet, i_clk, i_rst_n, i_cmd.accept, !r_mac_v,
                      "item accepted while a tap read is in flight")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for rgb_3x3_convolution_clamped
// Streams raster frames of RGB pixels into the filter and predicts every
// filtered pixel, with its position and end flags, from a behavioural copy of
// the line stores and registers. A short hand-written table comes first, then
// random frames under several register settings. Registers are written and
// read back over the APB port only while the filter is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int PIX_W          = rgbcc_pkg::PIX_W;
    localparam int CHANNELS       = rgbcc_pkg::CHANNELS;
    localparam int WORD_W         = rgbcc_pkg::WORD_W;
    localparam int COEF_W         = rgbcc_pkg::COEF_W;
    localparam int ROW_COEF_W     = rgbcc_pkg::ROW_COEF_W;
    localparam int GAIN_W         = rgbcc_pkg::GAIN_W;
    localparam int FRAC_W         = rgbcc_pkg::FRAC_W;
    localparam int OUT_COL_W      = rgbcc_pkg::OUT_COL_W;
    localparam int OUT_ROW_W      = rgbcc_pkg::OUT_ROW_W;
    localparam int PIXEL_MAX      = rgbcc_pkg::PIXEL_MAX;
    localparam int APB_ADDR_W     = rgbcc_pkg::APB_ADDR_W;
    localparam int APB_DATA_W     = rgbcc_pkg::APB_DATA_W;

    typedef rgbcc_pkg::t_cfg     t_cfg;
    typedef rgbcc_pkg::t_reg_idx t_reg_idx;

    localparam int FW             = rgbcc_pkg::FRAME_WIDTH_DEF;
    localparam int FH             = rgbcc_pkg::FRAME_HEIGHT_DEF;
    localparam int DIRECTED_ITEMS = 3 * FW;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 76;
    localparam int LONG_HOLD_AT   = 200;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 32;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic [OUT_COL_W-1:0] column;
        logic [OUT_ROW_W-1:0] row;
        logic                 run_last;
        logic                 frame_last;
    } t_filtered;

    // one row of the hand-written table; want_* checked on the first result
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             typed;
        logic [PIX_W-1:0] want_red;
        logic [PIX_W-1:0] want_green;
        logic [PIX_W-1:0] want_blue;
    } t_stim_row;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr        = '0;
    logic [APB_DATA_W-1:0]  pwdata       = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_stall;
    logic [PIX_W-1:0]       i_red_in     = '0;
    logic [PIX_W-1:0]       i_green_in   = '0;
    logic [PIX_W-1:0]       i_blue_in    = '0;
    logic                   o_out_valid;
    logic                   i_out_stall  = 1'b0;
    logic [PIX_W-1:0]       o_red_out;
    logic [PIX_W-1:0]       o_green_out;
    logic [PIX_W-1:0]       o_blue_out;
    logic [OUT_COL_W-1:0]   o_out_column;
    logic [OUT_ROW_W-1:0]   o_out_row;
    logic                   o_run_last;
    logic                   o_frame_last;

    // predictor state: registers, line stores and raster position
    t_cfg                   filter_cfg = '{rgbcc_pkg::COEFF_ABOVE_RST,
                                           rgbcc_pkg::COEFF_SAME_RST,
                                           rgbcc_pkg::COEFF_BELOW_RST,
                                           rgbcc_pkg::GAIN_RECIP_RST};
    logic [WORD_W-1:0]      line_mem [3][FW];
    int                     next_col = 0;
    int                     next_row = 0;
    t_filtered              awaited_pixels[$];

    int                     error_count   = 0;
    int                     pixels_sent   = 0;
    int                     cycle_count   = 0;
    int                     hold_left     = 0;
    bit                     long_hold_done = 1'b0;
    bit                     calm          = 1'b0;

    // rows 0-1 under an identity kernel (out = v - 1), row 2 under the
    // all-max kernel where a full-scale centre pixel saturates
    t_stim_row directed_rows [DIRECTED_ITEMS] = '{
        '{8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h80, 8'hFE, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h55, 8'hAA, 8'h0F, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hAA, 8'h55, 8'hF0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h7F, 8'h80, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'h00, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'hFF, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'h00, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 1'b1, 8'hFE, 8'hFE, 8'hFE},
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h7F, 8'hFD},
        '{8'h12, 8'h34, 8'h56, 1'b1, 8'h54, 8'hA9, 8'h0E},
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hA9, 8'h54, 8'hEF},
        '{8'h80, 8'h80, 8'h80, 1'b1, 8'h7E, 8'h7F, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFE, 8'h00, 8'h7F},
        '{8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF},
        '{8'h0F, 8'hF0, 8'h3C, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hC3, 8'h96, 8'h69, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'hFF, 8'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF},
        '{8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h02, 8'h04, 1'b1, 8'hFF, 8'hFF, 8'hFF},
        '{8'h80, 8'h40, 8'h20, 1'b0, 8'h00, 8'h00, 8'h00}
    };

    rgb_3x3_convolution_clamped dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // filtered pixel (x, y) from the current line stores and registers
    function automatic t_filtered filter_at(input int x, input int y);
        int                    rows [3];
        int                    cols [3];
        logic [ROW_COEF_W-1:0] coef [3];
        logic [PIX_W-1:0]      chan [3];
        logic [WORD_W-1:0]     pix;
        longint                sum;
        longint                scaled;
        int                    ch;
        int                    dy;
        int                    dx;
        t_filtered             res;
        rows[0] = (y == 0) ? 0 : y - 1;
        rows[1] = y;
        rows[2] = (y >= FH - 1) ? FH - 1 : y + 1;
        cols[0] = (x == 0) ? 0 : x - 1;
        cols[1] = x;
        cols[2] = (x >= FW - 1) ? FW - 1 : x + 1;
        coef[0] = filter_cfg.above;
        coef[1] = filter_cfg.same;
        coef[2] = filter_cfg.below;
        for (ch = 0; ch < CHANNELS; ch++) begin
            sum = 0;
            for (dy = 0; dy < 3; dy++) begin
                for (dx = 0; dx < 3; dx++) begin
                    pix = line_mem[rows[dy] % 3][cols[dx]];
                    // each product truncated before the sum
                    sum += (longint'(pix[PIX_W*ch +: PIX_W]) *
                            longint'(coef[dy][COEF_W*dx +: COEF_W])) >> FRAC_W;
                end
            end
            scaled = (sum * longint'(filter_cfg.gain)) >> GAIN_W;
            chan[ch] = (scaled > PIXEL_MAX) ? PIX_W'(PIXEL_MAX) : PIX_W'(scaled);
        end
        res.red        = chan[0];
        res.green      = chan[1];
        res.blue       = chan[2];
        res.column     = OUT_COL_W'(x);
        res.row        = OUT_ROW_W'(y);
        res.run_last   = 1'b0;
        res.frame_last = (x == FW - 1 && y == FH - 1);
        return res;
    endfunction

    // store one accepted pixel and queue the results it releases
    function automatic void predict_pixel(input logic [PIX_W-1:0] r, g, b,
                                          input logic typed,
                                          input logic [WORD_W-1:0] want);
        t_filtered batch[$];
        t_filtered head;
        int        c;
        int        rw;
        int        x;
        c  = next_col;
        rw = next_row;
        line_mem[rw % 3][c] = {b, g, r};
        if (rw >= 1) begin
            if (c >= 1) batch.push_back(filter_at(c - 1, rw - 1));
            if (c == FW - 1) batch.push_back(filter_at(c, rw - 1));
        end
        // final pixel flushes the bottom row
        if (c == FW - 1 && rw == FH - 1) begin
            for (x = 0; x < FW; x++) batch.push_back(filter_at(x, rw));
        end
        if (batch.size() > 0) begin
            if (typed) begin
                head = batch[0];
                {head.red, head.green, head.blue} = want;
                batch[0] = head;
            end
            head = batch[batch.size() - 1];
            head.run_last = 1'b1;
            batch[batch.size() - 1] = head;
        end
        foreach (batch[k]) awaited_pixels.push_back(batch[k]);
        next_col = c + 1;
        if (next_col == FW) begin
            next_col = 0;
            next_row = (rw == FH - 1) ? 0 : rw + 1;
        end
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_filtered(input t_filtered got);
        t_filtered want;
        if (awaited_pixels.size() == 0) begin
            $display("%0t: result expected none got column %0d row %0d",
                     $time, got.column, got.row);
            error_count++;
        end else begin
            want = awaited_pixels.pop_front();
            compare_field("red_out",    want.red,        got.red);
            compare_field("green_out",  want.green,      got.green);
            compare_field("blue_out",   want.blue,       got.blue);
            compare_field("out_column", want.column,     got.column);
            compare_field("out_row",    want.row,        got.row);
            compare_field("run_last",   want.run_last,   got.run_last);
            compare_field("frame_last", want.frame_last, got.frame_last);
        end
    endfunction

    function automatic logic [PIX_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // each coefficient drawn evenly from a gentle range or from the full range
    function automatic logic [ROW_COEF_W-1:0] random_row_coef();
        logic [ROW_COEF_W-1:0] v;
        int                    k;
        for (k = 0; k < 3; k++) begin
            v[COEF_W*k +: COEF_W] = ($urandom_range(0, 1) == 0) ?
                COEF_W'($urandom_range(0, 96)) : COEF_W'($urandom_range(0, 511));
        end
        return v;
    endfunction

    // one APB transfer: setup cycle, access cycle, then back to idle
    task automatic apb_transfer(input logic wr, input t_reg_idx idx,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_register(input t_reg_idx idx, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        apb_transfer(1'b0, idx, '0, got);
        if (got !== want) begin
            $display("%0t: register %s expected %0d got %0d", $time, idx.name(), want, got);
            error_count++;
        end
    endtask

    task automatic set_register(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        logic [APB_DATA_W-1:0] kept;
        apb_transfer(1'b1, idx, value, unused);
        case (idx)
            rgbcc_pkg::REG_COEFF_ABOVE: filter_cfg.above = value[ROW_COEF_W-1:0];
            rgbcc_pkg::REG_COEFF_SAME:  filter_cfg.same  = value[ROW_COEF_W-1:0];
            rgbcc_pkg::REG_COEFF_BELOW: filter_cfg.below = value[ROW_COEF_W-1:0];
            rgbcc_pkg::REG_GAIN_RECIP:  filter_cfg.gain  = value[GAIN_W-1:0];
            default: ;
        endcase
        kept = (idx == rgbcc_pkg::REG_GAIN_RECIP) ? APB_DATA_W'(value[GAIN_W-1:0])
                                                  : APB_DATA_W'(value[ROW_COEF_W-1:0]);
        read_register(idx, kept);
    endtask

    task automatic load_config(input t_cfg cfg);
        set_register(rgbcc_pkg::REG_COEFF_ABOVE, APB_DATA_W'(cfg.above));
        set_register(rgbcc_pkg::REG_COEFF_SAME,  APB_DATA_W'(cfg.same));
        set_register(rgbcc_pkg::REG_COEFF_BELOW, APB_DATA_W'(cfg.below));
        set_register(rgbcc_pkg::REG_GAIN_RECIP,  APB_DATA_W'(cfg.gain));
    endtask

    // offer one pixel, hold it until taken, then maybe go quiet for a while
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b,
                              input logic typed, input logic [WORD_W-1:0] want);
        i_in_valid <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel(r, g, b, typed, want);
        pixels_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // stop sending and let every queued result drain out
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side: check each taken item, stall in bursts, one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_filtered({o_red_out, o_green_out, o_blue_out, o_out_column,
                            o_out_row, o_run_last, o_frame_last});
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (pixels_sent >= LONG_HOLD_AT && !long_hold_done) begin
            i_out_stall    <= 1'b1;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_cfg next_cfg;
        int   i;
        int   phase;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers come up at their defaults
        read_register(rgbcc_pkg::REG_COEFF_ABOVE, APB_DATA_W'(rgbcc_pkg::COEFF_ABOVE_RST));
        read_register(rgbcc_pkg::REG_COEFF_SAME,  APB_DATA_W'(rgbcc_pkg::COEFF_SAME_RST));
        read_register(rgbcc_pkg::REG_COEFF_BELOW, APB_DATA_W'(rgbcc_pkg::COEFF_BELOW_RST));
        read_register(rgbcc_pkg::REG_GAIN_RECIP,  APB_DATA_W'(rgbcc_pkg::GAIN_RECIP_RST));

        // identity kernel with full gain for the first two rows
        load_config('{'0, ROW_COEF_W'(256 << COEF_W), '0, '1});
        for (i = 0; i < DIRECTED_ITEMS; i++) begin
            if (i == 2 * FW) begin
                settle_block();
                load_config('{'1, '1, '1, '1});
            end
            send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                       directed_rows[i].typed,
                       {directed_rows[i].want_red, directed_rows[i].want_green,
                        directed_rows[i].want_blue});
        end

        // random frames: defaults, all-max, all-zero (zero gain), then random
        for (phase = 0; phase < PHASES; phase++) begin
            settle_block();
            case (phase)
                0: next_cfg = '{rgbcc_pkg::COEFF_ABOVE_RST, rgbcc_pkg::COEFF_SAME_RST,
                                rgbcc_pkg::COEFF_BELOW_RST, rgbcc_pkg::GAIN_RECIP_RST};
                1: next_cfg = '{'1, '1, '1, '1};
                2: next_cfg = '{'0, '0, '0, '0};
                default: begin
                    next_cfg.above = random_row_coef();
                    next_cfg.same  = random_row_coef();
                    next_cfg.below = random_row_coef();
                    next_cfg.gain  = GAIN_W'($urandom_range(0, 65535));
                end
            endcase
            load_config(next_cfg);
            calm = (phase == PHASES - 1);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_pixel(random_level(), random_level(), random_level(), 1'b0, '0);
        end

        settle_block();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/rgbcc_pkg.sv
src/rgbcc_ram.sv
src/rgbcc_regs.sv
src/rgbcc_ctrl.sv
src/rgbcc_dp.sv
src/rgb_3x3_convolution_clamped.sv
sim/tb.sv
